/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the LED strip frame generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/lspfg_pkg.sv */
// Shared constants and types of the LED strip frame generator.
package lspfg_pkg;

  localparam int LED_TOTAL_DEF = 32;
  localparam int PAL_DEPTH_DEF = 16;

  localparam int CHAN_W      = 8;
  localparam int DELAY_W     = 16;
  localparam int LED_INDEX_W = 6;
  localparam int CFG_IDX_W   = 3;

  localparam int DIV_LANES = 3;
  localparam int DIV_W     = 16;
  localparam int DIVR_W    = 8;

  typedef logic [DIV_LANES-1:0][DIV_W-1:0]  div_lanes_t;
  typedef logic [DIV_LANES-1:0][DIVR_W-1:0] div_rem_t;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_RENDER  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;

  localparam logic [2:0] MODE_SOLID  = 3'd0;
  localparam logic [2:0] MODE_FLASH  = 3'd1;
  localparam logic [2:0] MODE_RIBBON = 3'd2;
  localparam logic [2:0] MODE_SCROLL = 3'd3;
  localparam logic [2:0] MODE_WIDE   = 3'd4;
  localparam logic [2:0] MODE_GRAD   = 3'd5;
  localparam logic [2:0] MODE_BANDS  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_STEPS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY = 3'd5;

endpackage

/* hw/rtl/lspfg_ram.sv */
// Simple memory with one write port and one registered read port.
module lspfg_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/lspfg_div.sv */
// Shared restoring divider with three lanes and a common divisor, one bit per cycle.
module lspfg_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  lspfg_pkg::div_lanes_t           dividend,
  input  logic [lspfg_pkg::DIVR_W-1:0]    divisor,
  output logic                            busy,
  output lspfg_pkg::div_lanes_t           quot,
  output lspfg_pkg::div_rem_t             rem
);

  localparam int CNT_W = $clog2(lspfg_pkg::DIV_W + 1);

  logic                         busy_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [lspfg_pkg::DIVR_W-1:0] d_r;
  lspfg_pkg::div_lanes_t        q_r;
  lspfg_pkg::div_rem_t          r_r;
  lspfg_pkg::div_lanes_t        q_nxt;
  lspfg_pkg::div_rem_t          r_nxt;

  always_comb begin
    logic [lspfg_pkg::DIVR_W:0] t;
    for (int l = 0; l < lspfg_pkg::DIV_LANES; l++) begin
      t = {r_r[l], q_r[l][lspfg_pkg::DIV_W-1]};
      if (t >= {1'b0, d_r}) begin
        r_nxt[l] = lspfg_pkg::DIVR_W'(t - {1'b0, d_r});
        q_nxt[l] = {q_r[l][lspfg_pkg::DIV_W-2:0], 1'b1};
      end else begin
        r_nxt[l] = lspfg_pkg::DIVR_W'(t);
        q_nxt[l] = {q_r[l][lspfg_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(lspfg_pkg::DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

/* hw/rtl/led_strip_pattern_frame_generator.sv */
// Top level of the LED strip frame generator: sequencer, palette, frame buffer and divider.
//
// Input beats carry a function code and a palette colour. A load beat writes one palette
// entry and a restart beat clears the step; both are taken while idle. A render beat
// builds the frame for the current step in the frame buffer and then sends one output
// beat per LED in LED order, the final one marked with last_led, and advances the step.
// in_stall stays high from a render beat until its final output beat has been taken.
// Two divisions on the shared divider set the fade position and the band widths, each
// LED costs one frame buffer write and one output beat, the scroll mode adds palette
// reads for each LED, and every faded band or frame adds its products and its division
// on the divider.
// A stall on the output simply holds the current beat; the sequencer waits for it.
// Configuration writes are always taken (cfg_ready is high) and belong in idle time.
// Reset clears the step, the registers to their defaults and all handshake state; the
// palette holds nothing defined until written.
module led_strip_pattern_frame_generator #(
  parameter int LED_TOTAL     = lspfg_pkg::LED_TOTAL_DEF,
  parameter int PALETTE_DEPTH = lspfg_pkg::PAL_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic [3:0]                          in_palette_index,
  input  logic [lspfg_pkg::CHAN_W-1:0]        in_red_in,
  input  logic [lspfg_pkg::CHAN_W-1:0]        in_green_in,
  input  logic [lspfg_pkg::CHAN_W-1:0]        in_blue_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lspfg_pkg::LED_INDEX_W-1:0]   out_led_index,
  output logic [lspfg_pkg::CHAN_W-1:0]        out_red_out,
  output logic [lspfg_pkg::CHAN_W-1:0]        out_green_out,
  output logic [lspfg_pkg::CHAN_W-1:0]        out_blue_out,
  output logic [lspfg_pkg::DELAY_W-1:0]       out_frame_delay,
  output logic                                out_last_led,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lspfg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lspfg_pkg::DELAY_W-1:0]       cfg_data
);

  localparam int N      = LED_TOTAL;
  localparam int PD     = PALETTE_DEPTH;
  localparam int LED_AW = (N > 1) ? $clog2(N) : 1;
  localparam int LED_CW = $clog2(N + 1);
  localparam int PAW    = $clog2(PD);
  localparam int LEN_W  = $clog2(PD + 1);
  localparam int TOT_W  = $clog2(PD * 255 + 1);
  localparam int COL_W  = 3 * lspfg_pkg::CHAN_W;
  localparam int CW     = lspfg_pkg::CHAN_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DSTEP, ST_DSTEP_W, ST_DBAND, ST_DBAND_W, ST_INIT, ST_BAND, ST_CUR,
    ST_NXT, ST_MIX1, ST_MIX2, ST_DMIX, ST_DMIX_W, ST_WR, ST_EM_RD, ST_EM_LD, ST_EM_HOLD
  } state_t;

  state_t state_r;

  logic [2:0]                     mode_r;
  logic [4:0]                     pal_len_r;
  logic                           dir_r;
  logic [7:0]                     grad_steps_r;
  logic [lspfg_pkg::DELAY_W-1:0]  hold_delay_r;
  logic [lspfg_pkg::DELAY_W-1:0]  step_delay_r;

  logic [TOT_W-1:0]   step_r;
  logic [PAW-1:0]     cn_r;
  logic [7:0]         p_r;
  logic [LED_CW-1:0]  shortw_r;
  logic [LEN_W-1:0]   longb_r;
  logic [PAW-1:0]     off_r;
  logic [LEN_W-1:0]   band_r;
  logic [LED_AW-1:0]  waddr_r;
  logic [LED_CW-1:0]  pos_r;
  logic [LED_CW-1:0]  w_r;
  logic [COL_W-1:0]   cur_r;
  logic [COL_W-1:0]   nxt_r;
  logic [COL_W-1:0]   color_r;
  lspfg_pkg::div_lanes_t prod_r;
  lspfg_pkg::div_lanes_t sum_r;
  logic [lspfg_pkg::DELAY_W-1:0] delay_r;
  logic [LED_AW-1:0]  eidx_r;

  logic                          out_valid_r;
  logic [lspfg_pkg::LED_INDEX_W-1:0] out_led_index_r;
  logic [COL_W-1:0]              out_color_r;
  logic [lspfg_pkg::DELAY_W-1:0] out_delay_r;
  logic                          out_last_r;

  logic [LEN_W-1:0]      len_c;
  logic [7:0]            s_c;
  logic [LEN_W+7:0]      ls_prod;
  logic [TOT_W-1:0]      total_c;
  logic [TOT_W:0]        step_inc;
  logic [PAW-1:0]        nxt_off;
  logic [LED_CW-1:0]     width_c;
  logic                  mixing;
  logic                  black;
  logic                  e_last;
  logic [LEN_W-1:0]      sc_off;
  logic [LED_AW-1:0]     wstart_c;

  logic                  pal_we;
  logic [PAW-1:0]        pal_raddr;
  logic [COL_W-1:0]      pal_rdata;
  logic                  fb_we;
  logic [LED_AW-1:0]     fb_raddr;
  logic [COL_W-1:0]      fb_rdata;

  logic                  div_start;
  logic                  div_busy;
  lspfg_pkg::div_lanes_t div_dividend;
  logic [7:0]            div_divisor;
  lspfg_pkg::div_lanes_t div_quot;
  lspfg_pkg::div_rem_t   div_rem;

  always_comb begin
    if (pal_len_r == 5'd0) begin
      len_c = LEN_W'(1);
    end else if (32'(pal_len_r) > PD) begin
      len_c = LEN_W'(PD);
    end else begin
      len_c = LEN_W'(pal_len_r);
    end
    s_c     = (grad_steps_r == 8'd0) ? 8'd1 : grad_steps_r;
    ls_prod = (LEN_W+8)'(len_c) * (LEN_W+8)'(s_c);
    unique case (mode_r)
      lspfg_pkg::MODE_FLASH:                         total_c = TOT_W'({len_c, 1'b0});
      lspfg_pkg::MODE_RIBBON, lspfg_pkg::MODE_SCROLL: total_c = TOT_W'(len_c);
      lspfg_pkg::MODE_WIDE:                          total_c = TOT_W'(N);
      lspfg_pkg::MODE_GRAD, lspfg_pkg::MODE_BANDS:    total_c = TOT_W'(ls_prod);
      default:                                       total_c = TOT_W'(1);
    endcase
    step_inc = {1'b0, step_r} + 1'b1;
    nxt_off  = (off_r == PAW'(len_c - 1'b1)) ? '0 : off_r + 1'b1;
    case (mode_r)
      lspfg_pkg::MODE_SCROLL: width_c = LED_CW'(1);
      lspfg_pkg::MODE_WIDE, lspfg_pkg::MODE_BANDS:
        width_c = (band_r < longb_r) ? shortw_r + 1'b1 : shortw_r;
      default: width_c = LED_CW'(N);
    endcase
    mixing = ((mode_r == lspfg_pkg::MODE_GRAD) || (mode_r == lspfg_pkg::MODE_BANDS)) &&
             (p_r != 8'd0);
    black  = (mode_r == lspfg_pkg::MODE_FLASH) && step_r[0];
    e_last = (eidx_r == LED_AW'(N - 1));
    sc_off = len_c - LEN_W'(step_r);
    wstart_c = '0;
    if (mode_r == lspfg_pkg::MODE_WIDE) begin
      if (dir_r) begin
        wstart_c = LED_AW'(step_r);
      end else if (step_r != '0) begin
        wstart_c = LED_AW'(LED_CW'(N) - LED_CW'(step_r));
      end
    end
  end

  assign pal_we    = (state_r == ST_IDLE) && in_valid && (in_func == lspfg_pkg::FUNC_LOAD) &&
                     (32'(in_palette_index) < PD);
  assign pal_raddr = (state_r == ST_CUR) ? nxt_off : off_r;
  assign fb_we     = (state_r == ST_WR);
  assign fb_raddr  = ((state_r == ST_EM_HOLD) && !e_last) ? eidx_r + 1'b1 : eidx_r;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = s_c;
    unique case (state_r)
      ST_DSTEP: begin
        div_start       = 1'b1;
        div_dividend[0] = lspfg_pkg::DIV_W'(step_r);
      end
      ST_DBAND: begin
        div_start       = 1'b1;
        div_dividend[0] = lspfg_pkg::DIV_W'(N);
        div_divisor     = 8'(len_c);
      end
      ST_DMIX: begin
        div_start    = 1'b1;
        div_dividend = sum_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lspfg_ram #(.DEPTH(PD), .WIDTH(COL_W)) u_palette (
    .clk   (clk),
    .wr_en (pal_we),
    .waddr (PAW'(in_palette_index)),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  lspfg_ram #(.DEPTH(N), .WIDTH(COL_W)) u_frame_buf (
    .clk   (clk),
    .wr_en (fb_we),
    .waddr (waddr_r),
    .wdata (color_r),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  lspfg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= lspfg_pkg::MODE_SOLID;
      pal_len_r    <= 5'd1;
      dir_r        <= 1'b0;
      grad_steps_r <= 8'd1;
      hold_delay_r <= '0;
      step_delay_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lspfg_pkg::CFG_MODE:       mode_r       <= cfg_data[2:0];
        lspfg_pkg::CFG_PAL_LEN:    pal_len_r    <= cfg_data[4:0];
        lspfg_pkg::CFG_DIRECTION:  dir_r        <= cfg_data[0];
        lspfg_pkg::CFG_GRAD_STEPS: grad_steps_r <= cfg_data[7:0];
        lspfg_pkg::CFG_HOLD_DELAY: hold_delay_r <= cfg_data;
        lspfg_pkg::CFG_STEP_DELAY: step_delay_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            case (in_func)
              lspfg_pkg::FUNC_RENDER: begin
                step_r  <= (step_r >= total_c) ? '0 : step_r;
                state_r <= ST_DSTEP;
              end
              lspfg_pkg::FUNC_RESTART: step_r <= '0;
              default: begin
              end
            endcase
          end
        end
        ST_DSTEP: state_r <= ST_DSTEP_W;
        ST_DSTEP_W: begin
          if (!div_busy) begin
            cn_r    <= PAW'(div_quot[0]);
            p_r     <= div_rem[0];
            state_r <= ST_DBAND;
          end
        end
        ST_DBAND: state_r <= ST_DBAND_W;
        ST_DBAND_W: begin
          if (!div_busy) begin
            shortw_r <= LED_CW'(div_quot[0]);
            longb_r  <= LEN_W'(div_rem[0]);
            state_r  <= ST_INIT;
          end
        end
        ST_INIT: begin
          band_r  <= '0;
          pos_r   <= '0;
          waddr_r <= wstart_c;
          delay_r <= (black || mixing) ? step_delay_r : hold_delay_r;
          case (mode_r)
            lspfg_pkg::MODE_FLASH: off_r <= PAW'(step_r >> 1);
            lspfg_pkg::MODE_RIBBON: off_r <= PAW'(step_r);
            lspfg_pkg::MODE_SCROLL: begin
              if (!dir_r) begin
                off_r <= PAW'(step_r);
              end else begin
                off_r <= (step_r == '0) ? '0 : PAW'(sc_off);
              end
            end
            lspfg_pkg::MODE_GRAD, lspfg_pkg::MODE_BANDS: off_r <= cn_r;
            default: off_r <= '0;
          endcase
          state_r <= ST_BAND;
        end
        ST_BAND: begin
          w_r     <= width_c;
          state_r <= ST_CUR;
        end
        ST_CUR: begin
          if (black) begin
            color_r <= '0;
            state_r <= ST_WR;
          end else if (mixing) begin
            cur_r   <= pal_rdata;
            state_r <= ST_NXT;
          end else begin
            color_r <= pal_rdata;
            state_r <= ST_WR;
          end
        end
        ST_NXT: begin
          nxt_r   <= pal_rdata;
          state_r <= ST_MIX1;
        end
        ST_MIX1: begin
          for (int l = 0; l < lspfg_pkg::DIV_LANES; l++) begin
            prod_r[l] <= lspfg_pkg::DIV_W'(cur_r[COL_W-1-CW*l -: CW]) *
                         lspfg_pkg::DIV_W'(s_c - p_r);
          end
          state_r <= ST_MIX2;
        end
        ST_MIX2: begin
          for (int l = 0; l < lspfg_pkg::DIV_LANES; l++) begin
            sum_r[l] <= prod_r[l] + lspfg_pkg::DIV_W'(nxt_r[COL_W-1-CW*l -: CW]) *
                                    lspfg_pkg::DIV_W'(p_r);
          end
          state_r <= ST_DMIX;
        end
        ST_DMIX: state_r <= ST_DMIX_W;
        ST_DMIX_W: begin
          if (!div_busy) begin
            color_r <= {div_quot[0][CW-1:0], div_quot[1][CW-1:0], div_quot[2][CW-1:0]};
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          waddr_r <= (waddr_r == LED_AW'(N - 1)) ? '0 : waddr_r + 1'b1;
          pos_r   <= pos_r + 1'b1;
          w_r     <= w_r - 1'b1;
          if (w_r == LED_CW'(1)) begin
            band_r <= band_r + 1'b1;
            off_r  <= nxt_off;
            if (pos_r == LED_CW'(N - 1)) begin
              eidx_r  <= '0;
              state_r <= ST_EM_RD;
            end else begin
              state_r <= ST_BAND;
            end
          end
        end
        ST_EM_RD: state_r <= ST_EM_LD;
        ST_EM_LD: begin
          out_valid_r     <= 1'b1;
          out_led_index_r <= lspfg_pkg::LED_INDEX_W'(eidx_r);
          out_color_r     <= fb_rdata;
          out_delay_r     <= delay_r;
          out_last_r      <= e_last;
          state_r         <= ST_EM_HOLD;
        end
        ST_EM_HOLD: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (e_last) begin
              step_r  <= (step_inc >= {1'b0, total_c}) ? '0 : TOT_W'(step_inc);
              state_r <= ST_IDLE;
            end else begin
              eidx_r  <= eidx_r + 1'b1;
              state_r <= ST_EM_LD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_led_index   = out_led_index_r;
  assign out_red_out     = out_color_r[COL_W-1 -: CW];
  assign out_green_out   = out_color_r[COL_W-1-CW -: CW];
  assign out_blue_out    = out_color_r[CW-1:0];
  assign out_frame_delay = out_delay_r;
  assign out_last_led    = out_last_r;

`include "assert_macros.svh"

  `ASSERT_NEVER(a_out_only_when_busy, clk, rst_n, out_valid && !in_stall)
  `ASSERT_NEVER(a_div_no_restart, clk, rst_n, div_start && div_busy)
  `ASSERT_CLK(a_last_index, clk, rst_n, (out_valid && out_last_led) |-> (out_led_index == lspfg_pkg::LED_INDEX_W'(N - 1)))

endmodule

/* test/tb_led_strip_pattern_frame_generator.sv */
// Self-checking testbench of the LED strip frame generator: directed table, then random phases.
module tb_led_strip_pattern_frame_generator;

  localparam int LEDS = 32;
  localparam int PAL = 16;

  typedef struct packed {
    logic [5:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] dly;
    logic        last;
  } led_beat_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  pidx;
    logic [23:0] rgb;
    logic        typed;
    logic [23:0] want;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_func;
  logic [3:0] in_palette_index;
  logic [7:0] in_red_in, in_green_in, in_blue_in;
  logic out_valid, out_stall;
  logic [5:0] out_led_index;
  logic [7:0] out_red_out, out_green_out, out_blue_out;
  logic [15:0] out_frame_delay;
  logic out_last_led;
  logic cfg_valid, cfg_ready;
  logic [lspfg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lspfg_pkg::DELAY_W-1:0] cfg_data;

  led_strip_pattern_frame_generator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_palette_index(in_palette_index), .in_red_in(in_red_in),
    .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_led_index(out_led_index),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_frame_delay(out_frame_delay),
    .out_last_led(out_last_led),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [23:0] pal_model [PAL];
  logic [23:0] frame_model [LEDS];
  int unsigned step_now;
  logic [2:0]  mode_reg;
  logic [4:0]  len_reg;
  logic        dir_reg;
  logic [7:0]  steps_reg;
  logic [15:0] hold_reg, blank_reg;
  logic [15:0] frame_dly;

  led_beat_t pending_leds[$];
  int errors;
  bit tx_idle_en, rx_idle_en, long_hold_req;

  logic [4:0] lens [5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4};
  logic [7:0] steps [5] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd7};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #24000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] mix_chan(int a, int b, int p, int s);
    return 8'((a * (s - p) + b * p) / s);
  endfunction

  function automatic logic [23:0] mix_rgb(logic [23:0] c0, logic [23:0] c1, int p, int s);
    return {mix_chan(c0[23:16], c1[23:16], p, s), mix_chan(c0[15:8], c1[15:8], p, s),
            mix_chan(c0[7:0], c1[7:0], p, s)};
  endfunction

  function automatic void band_span(int band, int len, output int start, output int width);
    int shortw, longb;
    shortw = LEDS / len;
    longb = LEDS % len;
    if (band < longb) begin
      start = band * (shortw + 1);
      width = shortw + 1;
    end else begin
      start = (shortw + 1) * longb + shortw * (band - longb);
      width = shortw;
    end
  endfunction

  // Builds the frame for the current step into frame_model and advances the step.
  function automatic void render_frame();
    int len, s, total, st, cn, p, off, start, width, pos;
    logic [23:0] colour, nxt;
    len = (len_reg == 0) ? 1 : (len_reg > PAL) ? PAL : int'(len_reg);
    s = (steps_reg == 0) ? 1 : int'(steps_reg);
    case (mode_reg)
      lspfg_pkg::MODE_FLASH: total = 2 * len;
      lspfg_pkg::MODE_RIBBON, lspfg_pkg::MODE_SCROLL: total = len;
      lspfg_pkg::MODE_WIDE: total = LEDS;
      lspfg_pkg::MODE_GRAD, lspfg_pkg::MODE_BANDS: total = len * s;
      default: total = 1;
    endcase
    if (step_now >= total) step_now = 0;
    st = step_now;
    frame_dly = hold_reg;
    case (mode_reg)
      lspfg_pkg::MODE_FLASH: begin
        colour = st[0] ? 24'h000000 : pal_model[(st / 2) % PAL];
        if (st[0]) frame_dly = blank_reg;
        foreach (frame_model[i]) frame_model[i] = colour;
      end
      lspfg_pkg::MODE_RIBBON: begin
        foreach (frame_model[i]) frame_model[i] = pal_model[st % PAL];
      end
      lspfg_pkg::MODE_SCROLL: begin
        foreach (frame_model[i]) begin
          off = dir_reg ? i + len - st : i + st;
          frame_model[i] = pal_model[off % len];
        end
      end
      lspfg_pkg::MODE_WIDE: begin
        for (int b = 0; b < len; b++) begin
          band_span(b, len, start, width);
          for (int i = 0; i < width; i++) begin
            pos = start + i + (dir_reg ? st : LEDS - st);
            frame_model[pos % LEDS] = pal_model[b];
          end
        end
      end
      lspfg_pkg::MODE_GRAD: begin
        cn = st / s;
        p = st % s;
        colour = pal_model[cn % PAL];
        if (p != 0) begin
          nxt = (cn + 1 >= len) ? pal_model[0] : pal_model[(cn + 1) % PAL];
          colour = mix_rgb(colour, nxt, p, s);
          frame_dly = blank_reg;
        end
        foreach (frame_model[i]) frame_model[i] = colour;
      end
      lspfg_pkg::MODE_BANDS: begin
        cn = st / s;
        p = st % s;
        if (p != 0) frame_dly = blank_reg;
        for (int b = 0; b < len; b++) begin
          off = (cn + b) % len;
          colour = pal_model[off];
          if (p != 0) begin
            nxt = (off == len - 1) ? pal_model[0] : pal_model[off + 1];
            colour = mix_rgb(colour, nxt, p, s);
          end
          band_span(b, len, start, width);
          for (int i = 0; i < width; i++)
            if (start + i < LEDS) frame_model[start + i] = colour;
        end
      end
      default: begin
        foreach (frame_model[i]) frame_model[i] = pal_model[0];
      end
    endcase
    step_now++;
    if (step_now >= total) step_now = 0;
  endfunction

  task automatic queue_frame(bit typed, logic [23:0] want);
    led_beat_t b;
    for (int i = 0; i < LEDS; i++) begin
      b.idx = 6'(i);
      {b.red, b.green, b.blue} = typed ? want : frame_model[i];
      b.dly = typed ? 16'h0000 : frame_dly;
      b.last = (i == LEDS - 1);
      pending_leds.push_back(b);
    end
  endtask

  task automatic send_beat(logic [1:0] func, logic [3:0] pidx, logic [23:0] rgb,
                           bit typed = 1'b0, logic [23:0] want = '0);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_palette_index <= pidx;
    {in_red_in, in_green_in, in_blue_in} <= rgb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (func)
      lspfg_pkg::FUNC_LOAD: pal_model[pidx] = rgb;
      lspfg_pkg::FUNC_RESTART: step_now = 0;
      lspfg_pkg::FUNC_RENDER: begin
        render_frame();
        queue_frame(typed, want);
      end
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [lspfg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lspfg_pkg::CFG_MODE: mode_reg = val[2:0];
      lspfg_pkg::CFG_PAL_LEN: len_reg = val[4:0];
      lspfg_pkg::CFG_DIRECTION: dir_reg = val[0];
      lspfg_pkg::CFG_GRAD_STEPS: steps_reg = val[7:0];
      lspfg_pkg::CFG_HOLD_DELAY: hold_reg = val;
      lspfg_pkg::CFG_STEP_DELAY: blank_reg = val;
      default: ;
    endcase
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    led_beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_led_index, out_red_out, out_green_out, out_blue_out, out_frame_delay,
              out_last_led};
      if (pending_leds.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected output beat %p", got);
      end else begin
        want = pending_leds.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Beat mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  stim_row_t directed [21] = '{
    '{lspfg_pkg::FUNC_LOAD,    4'd0,  24'h000000, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_RENDER,  4'd0,  24'h000000, 1'b1, 24'h000000},
    '{lspfg_pkg::FUNC_LOAD,    4'd0,  24'hFFFFFF, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_RENDER,  4'd0,  24'h000000, 1'b1, 24'hFFFFFF},
    '{lspfg_pkg::FUNC_SPARE,   4'd0,  24'h123456, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_RESTART, 4'd15, 24'hFFFFFF, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd1,  24'hFF0000, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd2,  24'h00FF00, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd3,  24'h0000FF, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd4,  24'h808080, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd5,  24'h7F7F7F, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd6,  24'h010203, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd7,  24'hFEFDFC, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd8,  24'hAA55AA, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd9,  24'h55AA55, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd10, 24'h00FFFF, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd11, 24'hFFFF00, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd12, 24'hFF00FF, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd13, 24'h0F0F0F, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd14, 24'hF0F0F0, 1'b0, 24'h0},
    '{lspfg_pkg::FUNC_LOAD,    4'd15, 24'h3C96E1, 1'b0, 24'h0}
  };

  initial begin
    int pick;
    errors = 0;
    step_now = 0;
    mode_reg = lspfg_pkg::MODE_SOLID;
    len_reg = 5'd1;
    dir_reg = 1'b0;
    steps_reg = 8'd1;
    hold_reg = '0;
    blank_reg = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = lspfg_pkg::FUNC_LOAD;
    in_palette_index = '0;
    {in_red_in, in_green_in, in_blue_in} = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r])
      send_beat(directed[r].func, directed[r].pidx, directed[r].rgb, directed[r].typed,
                directed[r].want);

    for (int ph = 0; ph < 16; ph++) begin
      settle();
      if (ph >= 14) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      write_reg(lspfg_pkg::CFG_MODE, 16'(ph % 8));
      write_reg(lspfg_pkg::CFG_PAL_LEN,
                (ph < 10) ? 16'(lens[ph % 5]) : 16'($urandom_range(0, 31)));
      write_reg(lspfg_pkg::CFG_DIRECTION, 16'((ph / 8) % 2));
      write_reg(lspfg_pkg::CFG_GRAD_STEPS,
                (ph < 10) ? 16'(steps[ph % 5]) : 16'($urandom_range(0, 255)));
      write_reg(lspfg_pkg::CFG_HOLD_DELAY, (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'h0000
                                          : 16'($urandom_range(0, 65535)));
      write_reg(lspfg_pkg::CFG_STEP_DELAY, (ph == 2) ? 16'hFFFF : (ph == 1) ? 16'h0000
                                          : 16'($urandom_range(0, 65535)));
      cfg_valid <= 1'b0;
      if (ph == 3) long_hold_req = 1'b1;
      for (int n = 0; n < 14; n++) begin
        if (ph == 5 && n == 7) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_leds.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        send_beat((pick < 70) ? lspfg_pkg::FUNC_RENDER : (pick < 85) ? lspfg_pkg::FUNC_LOAD :
                  (pick < 95) ? lspfg_pkg::FUNC_RESTART : lspfg_pkg::FUNC_SPARE,
                  4'($urandom_range(0, 15)), 24'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
